// ===== sv/dc_blocked_rms_meter_unit_macros.svh =====
// Assertion macros shared by the meter's RTL files.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef DC_BLOCKED_RMS_METER_UNIT_MACROS_SVH
`define DC_BLOCKED_RMS_METER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dbrm_pkg.sv =====
package dbrm_pkg;

  localparam int MAX_BLOCK = 1024;
  localparam int ADC_BITS  = 12;

  localparam int COEF_W  = 16;
  localparam int OUT_W   = 16;
  localparam int Y_W     = 32;
  localparam int YEXT_W  = 35;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
  localparam int SQ_W    = 47;
  localparam int SUM_W   = SQ_W + CNT_W - 1;
  localparam int MEAN_W  = SQ_W;
  localparam int ROOT_W  = 32;
  localparam int WORK_W  = 64;
  localparam int REM_W   = 34;
  localparam int CMP_W   = 36;
  localparam int CIDX_W  = 2;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [COEF_W-1:0] POLE_RESET = 16'd65208;
  localparam logic [COEF_W-1:0] VPL_RESET  = 16'd2230;
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_BLOCK);

  typedef enum logic [CIDX_W-1:0] {
    CFG_POLE_COEFF    = 2'd0,
    CFG_VOLTS_PER_LSB = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_mode_e;

  typedef struct packed {
    logic     start;
    ds_mode_e mode;
  } ds_ctrl_t;

endpackage

// ===== sv/dbrm_if.sv =====
interface dbrm_in_if;
  logic                          valid;
  logic                          ready;
  logic [dbrm_pkg::ADC_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface dbrm_out_if;
  logic                       valid;
  logic                       ready;
  logic [dbrm_pkg::OUT_W-1:0] rms_volts;
  logic                       saturated;

  modport source (output valid, output rms_volts, output saturated, input ready);
  modport sink (input valid, input rms_volts, input saturated, output ready);
endinterface

interface dbrm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dbrm_pkg::CIDX_W-1:0] index;
  logic [dbrm_pkg::COEF_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/dbrm_mul.sv =====
module dbrm_mul (
  input  logic                                clk_i,
  input  logic signed [dbrm_pkg::MUL_W-1:0]   a_i,
  input  logic signed [dbrm_pkg::MUL_W-1:0]   b_i,
  output logic signed [dbrm_pkg::PROD_W-1:0]  p_o
);

  logic signed [dbrm_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== sv/dbrm_divsqrt.sv =====
`include "dc_blocked_rms_meter_unit_macros.svh"

module dbrm_divsqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dbrm_pkg::ds_ctrl_t              ctrl_i,
  input  logic [dbrm_pkg::SUM_W-1:0]      dividend_i,
  input  logic [dbrm_pkg::CNT_W-1:0]      divisor_i,
  input  logic [dbrm_pkg::MEAN_W-1:0]     radicand_i,
  output logic                            done_o,
  output logic [dbrm_pkg::SUM_W-1:0]      res_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [dbrm_pkg::STEP_W-1:0]       step_q;
  dbrm_pkg::ds_mode_e                mode_q;
  logic [dbrm_pkg::WORK_W-1:0]       work_q;
  logic [dbrm_pkg::REM_W-1:0]        rem_q;
  logic [dbrm_pkg::SUM_W-1:0]        res_q;
  logic [dbrm_pkg::CNT_W-1:0]        den_q;

  logic [dbrm_pkg::CMP_W-1:0]        cand;
  logic [dbrm_pkg::CMP_W-1:0]        trial;
  logic [dbrm_pkg::CMP_W-1:0]        diff;
  logic                              ge;
  logic [dbrm_pkg::REM_W-1:0]        rem_nxt;
  logic [dbrm_pkg::WORK_W-1:0]       work_nxt;

  // One shared trial subtraction serves both the restoring divider and the
  // digit-by-digit square root.
  always_comb begin
    if (mode_q == dbrm_pkg::DS_SQRT) begin
      cand     = dbrm_pkg::CMP_W'({rem_q[dbrm_pkg::REM_W-2:0],
                                   work_q[dbrm_pkg::WORK_W-1:dbrm_pkg::WORK_W-2]});
      trial    = dbrm_pkg::CMP_W'({res_q[dbrm_pkg::ROOT_W-1:0], 2'b01});
      work_nxt = work_q << 2;
    end else begin
      cand     = dbrm_pkg::CMP_W'({rem_q[dbrm_pkg::CNT_W-1:0],
                                   work_q[dbrm_pkg::WORK_W-1]});
      trial    = dbrm_pkg::CMP_W'(den_q);
      work_nxt = work_q << 1;
    end
    diff    = cand - trial;
    ge      = ~diff[dbrm_pkg::CMP_W-1];
    rem_nxt = ge ? diff[dbrm_pkg::REM_W-1:0] : cand[dbrm_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      mode_q <= dbrm_pkg::DS_DIV;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        mode_q <= ctrl_i.mode;
        step_q <= (ctrl_i.mode == dbrm_pkg::DS_SQRT) ?
                  dbrm_pkg::STEP_W'(dbrm_pkg::SQRT_STEPS) :
                  dbrm_pkg::STEP_W'(dbrm_pkg::DIV_STEPS);
      end else if (busy_q) begin
        step_q <= step_q - dbrm_pkg::STEP_W'(1);
        if (step_q == dbrm_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      res_q <= '0;
      den_q <= divisor_i;
      if (ctrl_i.mode == dbrm_pkg::DS_SQRT) begin
        work_q <= dbrm_pkg::WORK_W'(radicand_i) << 16;
      end else begin
        work_q <= dbrm_pkg::WORK_W'(dividend_i) << (dbrm_pkg::WORK_W - dbrm_pkg::SUM_W);
      end
    end else if (busy_q) begin
      rem_q  <= rem_nxt;
      res_q  <= {res_q[dbrm_pkg::SUM_W-2:0], ge};
      work_q <= work_nxt;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `DBRM_ASSERT_NXT(a_start_busy, ctrl_i.start, busy_q, "Unit did not go busy after start.")
  `DBRM_ASSERT_IMP(a_done_idle, done_q, !busy_q, "Done raised while still iterating.")
  `DBRM_ASSERT_IMP(a_busy_steps, busy_q, step_q != '0, "Busy with no steps left.")

endmodule

// ===== sv/dc_blocked_rms_meter_unit.sv =====
// A sample passes the feedback multiply, filter, square multiply and accumulate states
// before the next sample can be taken. A sample flagged last then runs 57 divider steps,
// 32 root steps and the volts multiply on the shared units; its result is written once
// the result register is free, and only then is the next sample taken.
// Each sample uses two products on the shared multiplier.
// Reset clears the filter memory, the sum, the count and the output register, and
// loads the default coefficients.
`include "dc_blocked_rms_meter_unit_macros.svh"

module dc_blocked_rms_meter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbrm_cfg_if.sink    cfg_i,
  dbrm_in_if.sink     in_i,
  dbrm_out_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_FILT,
    ST_MUL_SQ,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_MUL_V,
    ST_VOLT
  } state_e;

  state_e                                state_q;
  logic [dbrm_pkg::COEF_W-1:0]           pole_q;
  logic [dbrm_pkg::COEF_W-1:0]           vpl_q;
  logic [dbrm_pkg::ADC_BITS-1:0]         x_q;
  logic                                  last_q;
  logic [dbrm_pkg::ADC_BITS-1:0]         prev_x_q;
  logic signed [dbrm_pkg::Y_W-1:0]       y_q;
  logic [dbrm_pkg::SUM_W-1:0]            sum_q;
  logic [dbrm_pkg::CNT_W-1:0]            cnt_q;
  logic                                  out_valid_q;
  logic [dbrm_pkg::OUT_W-1:0]            rms_q;
  logic                                  sat_q;

  logic signed [dbrm_pkg::MUL_W-1:0]     mul_a;
  logic signed [dbrm_pkg::MUL_W-1:0]     mul_b;
  logic signed [dbrm_pkg::PROD_W-1:0]    mul_p;
  logic [dbrm_pkg::Y_W-1:0]              y_mag;

  logic signed [48:0]                    fb_prod;
  logic signed [49:0]                    fb_rnd;
  logic signed [33:0]                    fb;
  logic signed [dbrm_pkg::ADC_BITS:0]    x_diff;
  logic signed [dbrm_pkg::YEXT_W-1:0]    y_wide;
  logic signed [dbrm_pkg::Y_W-1:0]       y_clamp;
  logic [62:0]                           sq_rnd;
  logic [dbrm_pkg::SQ_W-1:0]             sq;
  logic [48:0]                           v_rnd;
  logic [24:0]                           v_full;
  logic                                  v_sat;

  dbrm_pkg::ds_ctrl_t                    ds_ctrl;
  logic                                  ds_done;
  logic [dbrm_pkg::SUM_W-1:0]            ds_res;

  assign y_mag = y_q[dbrm_pkg::Y_W-1] ? (~y_q + dbrm_pkg::Y_W'(1)) : y_q;

  always_comb begin
    case (state_q)
      ST_MUL_FB: begin
        mul_a = dbrm_pkg::MUL_W'(pole_q);
        mul_b = dbrm_pkg::MUL_W'(y_q);
      end
      ST_MUL_SQ: begin
        mul_a = dbrm_pkg::MUL_W'(y_mag);
        mul_b = dbrm_pkg::MUL_W'(y_mag);
      end
      ST_MUL_V, ST_VOLT: begin
        mul_a = dbrm_pkg::MUL_W'(ds_res[dbrm_pkg::ROOT_W-1:0]);
        mul_b = dbrm_pkg::MUL_W'(vpl_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dbrm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // The filter output rounds the feedback product to 16 fraction bits and
  // clamps the result to the signed 32-bit range.
  always_comb begin
    fb_prod = mul_p[48:0];
    fb_rnd  = 50'(fb_prod) + 50'sd32768;
    fb      = fb_rnd[49:16];
    x_diff  = $signed({1'b0, x_q}) - $signed({1'b0, prev_x_q});
    y_wide  = (dbrm_pkg::YEXT_W'(x_diff) <<< 16) + dbrm_pkg::YEXT_W'(fb);
    if (y_wide > 35'sd2147483647) begin
      y_clamp = 32'sh7fffffff;
    end else if (y_wide < -35'sd2147483648) begin
      y_clamp = 32'sh80000000;
    end else begin
      y_clamp = y_wide[dbrm_pkg::Y_W-1:0];
    end
  end

  assign sq_rnd = mul_p[62:0] + 63'd32768;
  assign sq     = sq_rnd[62:16];
  assign v_rnd  = 49'(mul_p[47:0]) + 49'd8388608;
  assign v_full = v_rnd[48:24];
  assign v_sat  = |v_full[24:16];

  assign ds_ctrl.start = (state_q == ST_DIV_GO) || (state_q == ST_SQRT_GO);
  assign ds_ctrl.mode  = (state_q == ST_SQRT_GO) ? dbrm_pkg::DS_SQRT : dbrm_pkg::DS_DIV;

  dbrm_divsqrt u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ds_ctrl),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .radicand_i (ds_res[dbrm_pkg::MEAN_W-1:0]),
    .done_o     (ds_done),
    .res_o      (ds_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pole_q      <= dbrm_pkg::POLE_RESET;
      vpl_q       <= dbrm_pkg::VPL_RESET;
      x_q         <= '0;
      last_q      <= 1'b0;
      prev_x_q    <= '0;
      y_q         <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rms_q       <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          dbrm_pkg::CFG_POLE_COEFF:    pole_q <= cfg_i.data;
          dbrm_pkg::CFG_VOLTS_PER_LSB: vpl_q  <= cfg_i.data;
          default: begin
          end
        endcase
      end
      if (out_valid_q && out_o.ready && (state_q != ST_VOLT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            x_q     <= in_i.sample;
            last_q  <= in_i.last;
            state_q <= ST_MUL_FB;
          end
        end
        ST_MUL_FB: state_q <= ST_FILT;
        ST_FILT: begin
          prev_x_q <= x_q;
          y_q      <= y_clamp;
          state_q  <= ST_MUL_SQ;
        end
        ST_MUL_SQ: state_q <= ST_ACC;
        ST_ACC: begin
          if (cnt_q != dbrm_pkg::CNT_FULL) begin
            sum_q <= sum_q + dbrm_pkg::SUM_W'(sq);
            cnt_q <= cnt_q + dbrm_pkg::CNT_W'(1);
          end
          state_q <= last_q ? ST_DIV_GO : ST_IDLE;
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (ds_done) begin
            state_q <= ST_SQRT_GO;
          end
        end
        ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (ds_done) begin
            state_q <= ST_MUL_V;
          end
        end
        ST_MUL_V: state_q <= ST_VOLT;
        ST_VOLT: begin
          if (!out_valid_q || out_o.ready) begin
            rms_q       <= v_sat ? {dbrm_pkg::OUT_W{1'b1}} : v_full[dbrm_pkg::OUT_W-1:0];
            sat_q       <= v_sat;
            out_valid_q <= 1'b1;
            sum_q       <= '0;
            cnt_q       <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.rms_volts = rms_q;
  assign out_o.saturated = sat_q;

  `DBRM_ASSERT_NXT(a_busy_after_in, in_i.valid && in_i.ready, !in_i.ready, "Ready stayed high after a sample transfer.")
  `DBRM_ASSERT_IMP(a_done_in_wait, ds_done, (state_q == ST_DIV_WAIT) || (state_q == ST_SQRT_WAIT), "Divide/root unit finished outside a wait state.")
  `DBRM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= dbrm_pkg::CNT_FULL, "Sample count exceeded the block limit.")
  `DBRM_ASSERT_IMP(a_out_from_volt, $rose(out_valid_q), $past(state_q) == ST_VOLT, "Result appeared without a volts step.")

endmodule

// ===== tb/tb_dc_blocked_rms_meter_unit.sv =====
module tb_dc_blocked_rms_meter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dbrm_pkg::CIDX_W-1:0] CFG_POLE_COEFF    = dbrm_pkg::CFG_POLE_COEFF;
  localparam logic [dbrm_pkg::CIDX_W-1:0] CFG_VOLTS_PER_LSB = dbrm_pkg::CFG_VOLTS_PER_LSB;
  localparam logic [dbrm_pkg::CIDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [dbrm_pkg::CIDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam longint Y_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Y_MIN = -64'sh0000_0000_8000_0000;
  localparam int MAX_PRINTED = 200;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef enum int {
    WAVE_NOISE,
    WAVE_DC,
    WAVE_SQUARE,
    WAVE_JITTER,
    WAVE_RAMP
  } wave_e;

  typedef struct packed {
    logic [dbrm_pkg::OUT_W-1:0] rms;
    logic                       sat;
  } rms_result_t;

  typedef struct packed {
    row_kind_e                     kind;
    logic [dbrm_pkg::CIDX_W-1:0]   idx;
    logic [dbrm_pkg::COEF_W-1:0]   data;
    logic [dbrm_pkg::ADC_BITS-1:0] sample;
    logic                          last;
    logic                          known;
    logic [dbrm_pkg::OUT_W-1:0]    exp_rms;
    logic                          exp_sat;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [29] = '{
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd0,    1'b1, 1'b1, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b1, 1'b1, 16'd35671, 1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd2048, 1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd2048, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd2048, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd2048, 1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd1,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4094, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd2730, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd1365, 1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_POLE_COEFF,    16'd0,     12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_VOLTS_PER_LSB, 16'd65535, 12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b1, 1'b1, 16'd65535, 1'b1},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b1, 1'b1, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_VOLTS_PER_LSB, 16'd0,     12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd0,    1'b1, 1'b1, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_POLE_COEFF,    16'd65535, 12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_VOLTS_PER_LSB, 16'd65535, 12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd4095, 1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_SPARE_A,       16'hFFFF,  12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,    CFG_SPARE_B,       16'h5555,  12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_SAMPLE, CFG_POLE_COEFF,    16'd0,     12'd2048, 1'b1, 1'b0, 16'd0,     1'b0}
  };

  logic clk_i;
  logic rst_ni;

  dbrm_cfg_if cfg_bus ();
  dbrm_in_if  in_bus ();
  dbrm_out_if out_bus ();

  dc_blocked_rms_meter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic [dbrm_pkg::COEF_W-1:0]   reg_pole;
  logic [dbrm_pkg::COEF_W-1:0]   reg_vpl;
  logic [dbrm_pkg::ADC_BITS-1:0] filt_x;
  longint                        filt_y;
  longint unsigned               sq_sum;
  int                            blk_count;

  rms_result_t rms_expected[$];
  int          mismatches;
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Filters one sample, accumulates its square while the block holds fewer than MAX_BLOCK
  // samples and, on the last sample of a block, computes the RMS reading in volts.
  task automatic meter_step(input logic [dbrm_pkg::ADC_BITS-1:0] x, input logic is_last,
                            output bit produced, output rms_result_t res);
    longint          fb;
    longint          y;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned volts;
    fb = (longint'(reg_pole) * filt_y + 64'sd32768) >>> 16;
    y = (longint'(x) - longint'(filt_x)) * 64'sd65536 + fb;
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    filt_x = x;
    filt_y = y;
    if (blk_count < dbrm_pkg::MAX_BLOCK) begin
      mag = (y < 0) ? -y : y;
      sq = (mag * mag + 64'd32768) >> 16;
      if (sq_sum > ~64'd0 - sq) sq_sum = ~64'd0;
      else sq_sum = sq_sum + sq;
      blk_count++;
    end
    produced = is_last;
    res = '0;
    if (is_last) begin
      mean = sq_sum / longint'(blk_count);
      if (mean > (~64'd0 >> 16)) mean = ~64'd0 >> 16;
      root = int_sqrt(mean << 16);
      if (root > 64'hFF_FFFF_FFFF) root = 64'hFF_FFFF_FFFF;
      volts = (root * longint'(reg_vpl) + (64'd1 << 23)) >> 24;
      res.sat = volts > 64'hFFFF;
      res.rms = res.sat ? 16'hFFFF : volts[dbrm_pkg::OUT_W-1:0];
      sq_sum = 0;
      blk_count = 0;
    end
  endtask

  task automatic write_reg(input logic [dbrm_pkg::CIDX_W-1:0] idx,
                           input logic [dbrm_pkg::COEF_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_POLE_COEFF:    reg_pole = val;
      CFG_VOLTS_PER_LSB: reg_vpl = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_sample(input logic [dbrm_pkg::ADC_BITS-1:0] s, input logic l,
                              input logic known, input rms_result_t typed);
    int          gap;
    bit          produced;
    rms_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_bus.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_bus.valid  = 1'b1;
    in_bus.sample = s;
    in_bus.last   = l;
    do @(posedge clk_i); while (!in_bus.ready);
    meter_step(s, l, produced, res);
    if (produced) begin
      rms_expected.push_back(known ? typed : res);
    end
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_idle(input int settle);
    in_bus.valid = 1'b0;
    while (rms_expected.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  function automatic logic [dbrm_pkg::ADC_BITS-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return dbrm_pkg::ADC_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [dbrm_pkg::ADC_BITS-1:0] wave_sample(input wave_e shape,
      input int i, input logic [dbrm_pkg::ADC_BITS-1:0] a,
      input logic [dbrm_pkg::ADC_BITS-1:0] b);
    case (shape)
      WAVE_NOISE:  return dbrm_pkg::ADC_BITS'($urandom);
      WAVE_DC:     return a;
      WAVE_SQUARE: return i[0] ? b : a;
      WAVE_JITTER: return a ^ dbrm_pkg::ADC_BITS'($urandom_range(0, 15));
      default:     return a + dbrm_pkg::ADC_BITS'(i * int'(b[5:0]));
    endcase
  endfunction

  task automatic run_block(input int len);
    wave_e                         shape;
    logic [dbrm_pkg::ADC_BITS-1:0] a;
    logic [dbrm_pkg::ADC_BITS-1:0] b;
    shape = wave_e'($urandom_range(0, 4));
    a = pick_level();
    b = pick_level();
    for (int i = 0; i < len; i++) begin
      drive_sample(wave_sample(shape, i, a, b), i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [dbrm_pkg::COEF_W-1:0] pole,
                           input logic [dbrm_pkg::COEF_W-1:0] vpl,
                           input int n_items, input bit with_long);
    int sent;
    int len;
    int r;
    wait_idle(16);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_POLE_COEFF, pole);
      write_reg(CFG_VOLTS_PER_LSB, vpl);
    end else begin
      write_reg(CFG_VOLTS_PER_LSB, vpl);
      write_reg(CFG_POLE_COEFF, pole);
    end
    sent = 0;
    if (with_long) begin
      len = $urandom_range(dbrm_pkg::MAX_BLOCK, dbrm_pkg::MAX_BLOCK + 8);
      run_block(len);
      sent = len;
    end
    while (sent < n_items + (with_long ? dbrm_pkg::MAX_BLOCK : 0)) begin
      r = $urandom_range(0, 19);
      if (r < 13) len = $urandom_range(1, 8);
      else if (r < 19) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 160);
      run_block(len);
      sent += len;
    end
  endtask

  initial begin
    logic [15:0] pat;
    int          age;
    out_bus.ready = 1'b0;
    pat = 16'hFFFF;
    age = 0;
    forever begin
      @(negedge clk_i);
      if (age == 0) begin
        age = 64;
        case ($urandom_range(0, 3))
          0: pat = 16'hFFFF;
          1: pat = 16'($urandom);
          2: pat = 16'($urandom) | 16'($urandom);
          default: pat = 16'($urandom) & 16'($urandom);
        endcase
      end
      out_bus.ready = pat[0];
      pat = {pat[0], pat[15:1]};
      age--;
    end
  end

  always @(posedge clk_i) begin
    rms_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (rms_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result rms_volts %0d saturated %0b",
                                  out_bus.rms_volts, out_bus.saturated));
      end else begin
        want = rms_expected.pop_front();
        if (out_bus.rms_volts !== want.rms) begin
          report_mismatch($sformatf("rms_volts got %0d want %0d",
                                    out_bus.rms_volts, want.rms));
        end
        if (out_bus.saturated !== want.sat) begin
          report_mismatch($sformatf("saturated got %0b want %0b",
                                    out_bus.saturated, want.sat));
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.last    = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_POLE_COEFF;
    cfg_bus.data   = '0;
    reg_pole       = dbrm_pkg::POLE_RESET;
    reg_vpl        = dbrm_pkg::VPL_RESET;
    filt_x         = '0;
    filt_y         = 0;
    sq_sum         = 0;
    blk_count      = 0;
    mismatches     = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    for (int r = 0; r < $size(DIR_ROWS); r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_CFG) begin
        wait_idle(16);
        write_reg(row.idx, row.data);
      end else begin
        drive_sample(row.sample, row.last, row.known, '{row.exp_rms, row.exp_sat});
      end
    end

    run_phase(dbrm_pkg::POLE_RESET, dbrm_pkg::VPL_RESET, 60, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 60, 1'b0);
    run_phase(16'h0000, 16'h0000, 60, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 60, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 60, 1'b0);
    run_phase(16'hFFFF, 16'h0001, 60, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 60, 1'b1);
    repeat (3) run_phase(16'($urandom), 16'($urandom_range(1000, 65535)), 60, 1'b0);

    wait_idle(120);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
